[src/bpq_pkg.sv]
`default_nettype none
package bpq_pkg;

  // Fixed widths of the port fields
  localparam int IN_PRIO_W = 6;
  localparam int DATA_W    = 16;
  localparam int OCC_W     = 11;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic push_rd;
    logic push_wr;
    logic scan_step;
    logic pop_head_rd;
    logic pop_ent_rd;
    logic pop_wr;
    logic emit_full;
    logic emit_empty;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic cur_end;
    logic cur_nonempty;
  } dp_stat_t;

endpackage
`default_nettype wire

[src/bucket_priority_queue_lifo.sv]
`default_nettype none
// Bucket priority queue: one LIFO stack per level over a shared linked entry
// store. A command is taken when start is high and busy is low; its single
// result appears on the out_ ports for exactly one cycle, marked by out_valid,
// in the cycle after the command's last working cycle; the receiver cannot
// stall it. A push accepts, reads the level top and free link, then writes
// back; a push into a full store skips the read and the write. A pop has
// the scan cursor step over the empty levels one per cycle, then reads the
// level top and then the entry, each through a registered memory port, and
// writes back; a pop on an empty queue ends once the cursor passes the last level.
// The entry store needs no clearing after reset: never-used entries are
// handed out in order by a fill pointer.
module bucket_priority_queue_lifo
  import bpq_pkg::*;
#(
  parameter int NUM_LEVELS    = 64,
  parameter int CAPACITY      = 1024,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_cmd,
  input  wire logic [IN_PRIO_W-1:0] in_priority_req,
  input  wire logic [DATA_W-1:0]    in_payload,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [DATA_W-1:0]         out_payload,
  output logic [IN_PRIO_W-1:0]      out_priority,
  output logic [OCC_W-1:0]          out_occupancy
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  bpq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd),
    .busy   (busy)
  );

  bpq_dp #(
    .NUM_LEVELS    (NUM_LEVELS),
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_i           (dp_cmd),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .stat_o          (dp_stat),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_payload     (out_payload),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy)
  );

endmodule
`default_nettype wire

[src/bpq_ctrl.sv]
`default_nettype none
module bpq_ctrl
  import bpq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_cmd,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o,
  output logic          busy
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_PUSH_RD  = 6'b000010,
    S_PUSH_WR  = 6'b000100,
    S_SCAN     = 6'b001000,
    S_POP_HEAD = 6'b010000,
    S_POP_ENT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    busy      = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          if (cmd_code_t'(in_cmd) == CMD_POP) begin
            state_nxt = S_SCAN;
          end else if (stat_i.full) begin
            cmd_o.emit_full = 1'b1;
          end else begin
            state_nxt = S_PUSH_RD;
          end
        end
      end
      S_PUSH_RD: begin
        cmd_o.push_rd = 1'b1;
        state_nxt     = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        cmd_o.push_wr = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.cur_end) begin
          cmd_o.emit_empty = 1'b1;
          state_nxt        = S_IDLE;
        end else if (stat_i.cur_nonempty) begin
          cmd_o.pop_head_rd = 1'b1;
          state_nxt         = S_POP_HEAD;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_POP_HEAD: begin
        cmd_o.pop_ent_rd = 1'b1;
        state_nxt        = S_POP_ENT;
      end
      S_POP_ENT: begin
        cmd_o.pop_wr = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/bpq_dp.sv]
`default_nettype none
module bpq_dp
  import bpq_pkg::*;
#(
  parameter int NUM_LEVELS    = 64,
  parameter int CAPACITY      = 1024,
  parameter int PAYLOAD_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd_i,
  input  wire logic [IN_PRIO_W-1:0] in_priority_req,
  input  wire logic [DATA_W-1:0]    in_payload,
  output dp_stat_t                  stat_o,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [DATA_W-1:0]         out_payload,
  output logic [IN_PRIO_W-1:0]      out_priority,
  output logic [OCC_W-1:0]          out_occupancy
);

  localparam int LW   = $clog2(NUM_LEVELS);
  localparam int CURW = $clog2(NUM_LEVELS + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int LKW  = $clog2(CAPACITY + 1);
  localparam int PW   = PAYLOAD_WIDTH;
  localparam int EW   = LKW + PW;

  localparam logic [LKW-1:0]  LINK_NULL = LKW'(CAPACITY);
  localparam logic [CURW-1:0] CUR_END   = CURW'(NUM_LEVELS);

  // Memories: per-level stack tops, and the shared entry store {next, payload}
  logic [LKW-1:0] level_head_mem [NUM_LEVELS];
  logic [EW-1:0]  entry_mem      [CAPACITY];

  // Control state
  logic [NUM_LEVELS-1:0] nonempty_r, nonempty_nxt;
  logic [LKW-1:0]        free_head_r, free_head_nxt;  // recycled entries only
  logic [LKW-1:0]        fill_r, fill_nxt;            // entries never yet used start here
  logic [CURW-1:0]       cursor_r, cursor_nxt;
  logic [LKW-1:0]        count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Item and read data
  logic [LW-1:0]  lvl_r, lvl_in;
  logic [PW-1:0]  pay_r, pay_in;
  logic [LKW-1:0] lh_rd_r;
  logic [EW-1:0]  ent_rd_r;

  logic [1:0]           out_status_r, out_status_nxt;
  logic [DATA_W-1:0]    out_payload_r, out_payload_nxt;
  logic [IN_PRIO_W-1:0] out_priority_r, out_priority_nxt;
  logic [OCC_W-1:0]     out_occ_r, out_occ_nxt;

  logic [LW-1:0]     cursor_idx;
  logic              recycled;
  logic [LKW-1:0]    slot;
  logic [LKW-1:0]    push_link;
  logic [LKW-1:0]    ent_next;
  logic [PW-1:0]     ent_pay;
  logic [DATA_W-1:0] pop_pay;

  logic              lh_re, lh_we;
  logic [LW-1:0]     lh_ra, lh_wa;
  logic [LKW-1:0]    lh_wd;
  logic              en_re, en_we;
  logic [IW-1:0]     en_ra, en_wa;
  logic [EW-1:0]     en_wd;

  genvar gi;

  generate
    for (gi = 0; gi < PW; gi++) begin : g_pay_in
      if (gi < DATA_W) begin : g_bit
        assign pay_in[gi] = in_payload[gi];
      end else begin : g_zero
        assign pay_in[gi] = 1'b0;
      end
    end
    for (gi = 0; gi < DATA_W; gi++) begin : g_pay_out
      if (gi < PW) begin : g_bit
        assign pop_pay[gi] = ent_pay[gi];
      end else begin : g_zero
        assign pop_pay[gi] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    if (int'(in_priority_req) >= NUM_LEVELS) begin
      lvl_in = LW'(NUM_LEVELS - 1);
    end else begin
      lvl_in = LW'(in_priority_req);
    end
  end

  assign cursor_idx = cursor_r[LW-1:0];
  assign recycled   = (free_head_r != LINK_NULL);
  assign slot       = recycled ? free_head_r : fill_r;
  assign push_link  = nonempty_r[lvl_r] ? lh_rd_r : LINK_NULL;
  assign ent_next   = ent_rd_r[EW-1:PW];
  assign ent_pay    = ent_rd_r[PW-1:0];

  assign stat_o.full         = (count_r == LKW'(CAPACITY));
  assign stat_o.cur_end      = (cursor_r == CUR_END);
  assign stat_o.cur_nonempty = (cursor_r != CUR_END) && nonempty_r[cursor_idx];

  // Memory port muxing
  assign lh_re = cmd_i.push_rd | cmd_i.pop_head_rd;
  assign lh_ra = cmd_i.push_rd ? lvl_r : cursor_idx;
  assign lh_we = cmd_i.push_wr | cmd_i.pop_wr;
  assign lh_wa = cmd_i.push_wr ? lvl_r : cursor_idx;
  assign lh_wd = cmd_i.push_wr ? slot : ent_next;

  assign en_re = (cmd_i.push_rd & recycled) | cmd_i.pop_ent_rd;
  assign en_ra = cmd_i.push_rd ? free_head_r[IW-1:0] : lh_rd_r[IW-1:0];
  assign en_we = cmd_i.push_wr | cmd_i.pop_wr;
  assign en_wa = cmd_i.push_wr ? slot[IW-1:0] : lh_rd_r[IW-1:0];
  assign en_wd = cmd_i.push_wr ? {push_link, pay_r} : {free_head_r, ent_pay};

  always_ff @(posedge clk) begin
    if (lh_we) begin
      level_head_mem[lh_wa] <= lh_wd;
    end
    if (lh_re) begin
      lh_rd_r <= level_head_mem[lh_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (en_we) begin
      entry_mem[en_wa] <= en_wd;
    end
    if (en_re) begin
      ent_rd_r <= entry_mem[en_ra];
    end
  end

  always_comb begin
    nonempty_nxt     = nonempty_r;
    free_head_nxt    = free_head_r;
    fill_nxt         = fill_r;
    cursor_nxt       = cursor_r;
    count_nxt        = count_r;
    out_valid_nxt    = cmd_i.push_wr | cmd_i.pop_wr | cmd_i.emit_full | cmd_i.emit_empty;
    out_status_nxt   = out_status_r;
    out_payload_nxt  = out_payload_r;
    out_priority_nxt = out_priority_r;
    out_occ_nxt      = out_occ_r;

    if (cmd_i.scan_step) begin
      cursor_nxt = cursor_r + CURW'(1);
    end

    if (cmd_i.push_wr) begin
      nonempty_nxt[lvl_r] = 1'b1;
      if (recycled) begin
        free_head_nxt = ent_next;
      end else begin
        fill_nxt = fill_r + LKW'(1);
      end
      if (CURW'(lvl_r) < cursor_r) begin
        cursor_nxt = CURW'(lvl_r);
      end
      count_nxt = count_r + LKW'(1);
    end

    if (cmd_i.pop_wr) begin
      nonempty_nxt[cursor_idx] = (ent_next != LINK_NULL);
      free_head_nxt            = lh_rd_r;
      if (count_r != '0) begin
        count_nxt = count_r - LKW'(1);
      end
    end

    if (cmd_i.push_wr || cmd_i.emit_full || cmd_i.emit_empty) begin
      out_payload_nxt  = '0;
      out_priority_nxt = '0;
    end
    if (cmd_i.push_wr) begin
      out_status_nxt = ST_PUSHED;
    end
    if (cmd_i.emit_full) begin
      out_status_nxt = ST_FULL;
    end
    if (cmd_i.emit_empty) begin
      out_status_nxt = ST_EMPTY;
    end
    if (cmd_i.pop_wr) begin
      out_status_nxt   = ST_POPPED;
      out_payload_nxt  = pop_pay;
      out_priority_nxt = IN_PRIO_W'(cursor_r);
    end
    if (out_valid_nxt) begin
      out_occ_nxt = OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r  <= '0;
      free_head_r <= LINK_NULL;
      fill_r      <= '0;
      cursor_r    <= CURW'(NUM_LEVELS - 1);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      nonempty_r  <= nonempty_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      lvl_r <= lvl_in;
      pay_r <= pay_in;
    end
    out_status_r   <= out_status_nxt;
    out_payload_r  <= out_payload_nxt;
    out_priority_r <= out_priority_nxt;
    out_occ_r      <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_payload   = out_payload_r;
  assign out_priority  = out_priority_r;
  assign out_occupancy = out_occ_r;

`ifndef SYNTH
  a_count_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fill_r)
    else $error("entry count above high-water mark");

  a_fill_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LKW'(CAPACITY))
    else $error("high-water mark past capacity");

  a_parked_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_r == CUR_END) |-> (nonempty_r == '0))
    else $error("cursor parked while a level holds entries");

  a_recycled_free: assert property (@(posedge clk) disable iff (!rst_n)
    (free_head_r != LINK_NULL) |-> (count_r < fill_r))
    else $error("recycled list not empty while every used entry is held");

  a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.push_wr |=> (out_valid && out_status == ST_PUSHED &&
                       out_occupancy == OCC_W'($past(count_r) + LKW'(1))))
    else $error("push result wrong");
`endif

endmodule
`default_nettype wire
